@@ rtl/bsmh_pkg.sv @@
// Shared constants and types for the box stacking height unit.
package bsmh_pkg;
    localparam int MaxBoxes  = 64;
    localparam int DimWidth  = 10;
    localparam int IdxW      = $clog2(MaxBoxes);
    localparam int CntW      = $clog2(MaxBoxes + 1);
    localparam int HeightW   = 16;
    localparam int BoxW      = 3 * DimWidth;
    localparam int SumW      = DimWidth + 2;
    localparam int QDepth    = 4;
    localparam int QPtrW     = $clog2(QDepth);

    // One word passed from the front end to the solver.
    typedef struct packed {
        logic [BoxW-1:0] box;
        logic            last;
        logic            drop;
    } t_qword;

    typedef logic [HeightW-1:0] t_height;
endpackage

@@ rtl/bsmh_front.sv @@
// Front end: sorts the three dimensions of each box and queues the box.
module bsmh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bsmh_pkg::DimWidth-1:0] i_dim_a,
    input  logic [bsmh_pkg::DimWidth-1:0] i_dim_b,
    input  logic [bsmh_pkg::DimWidth-1:0] i_dim_c,
    input  logic                         i_last_box,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output bsmh_pkg::t_qword             o_q_word
);
    localparam int Dw = bsmh_pkg::DimWidth;

    bsmh_pkg::t_qword r_mem [bsmh_pkg::QDepth];
    logic [bsmh_pkg::QPtrW-1:0] r_wp, r_rp;
    logic [bsmh_pkg::QPtrW:0]   r_cnt;
    logic [bsmh_pkg::CntW-1:0]  r_count;
    logic [Dw-1:0] s0a, s0b, s1b, s1c, s2a, s2b;
    logic          push, pop;
    bsmh_pkg::t_qword w;

    // three compare-exchange steps
    always_comb begin
        s0a = (i_dim_a > i_dim_b) ? i_dim_b : i_dim_a;
        s0b = (i_dim_a > i_dim_b) ? i_dim_a : i_dim_b;
        s1b = (s0b > i_dim_c) ? i_dim_c : s0b;
        s1c = (s0b > i_dim_c) ? s0b : i_dim_c;
        s2a = (s0a > s1b) ? s1b : s0a;
        s2b = (s0a > s1b) ? s0a : s1b;
        w.box  = {s1c, s2b, s2a};
        w.last = i_last_box;
        w.drop = (r_count == bsmh_pkg::CntW'(bsmh_pkg::MaxBoxes));
    end

    assign o_ready   = (r_cnt != (bsmh_pkg::QPtrW+1)'(bsmh_pkg::QDepth));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w;
        end
    end

    // queue pointers and per-set box count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
                if (i_last_box) begin
                    r_count <= '0;
                end else if (!w.drop) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (bsmh_pkg::QPtrW+1)'(push) - (bsmh_pkg::QPtrW+1)'(pop);
        end
    end
endmodule

@@ rtl/bsmh_back.sv @@
// Back end: stores boxes, then runs the chain-height program per set.
module bsmh_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  bsmh_pkg::t_qword      i_q_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [bsmh_pkg::HeightW-1:0] o_max_height,
    output logic                  o_overflow
);
    localparam int Iw = bsmh_pkg::IdxW;
    localparam int Cw = bsmh_pkg::CntW;
    localparam int Dw = bsmh_pkg::DimWidth;
    localparam int Hw = bsmh_pkg::HeightW;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_PICK  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic [bsmh_pkg::BoxW-1:0] r_box [bsmh_pkg::MaxBoxes];
    logic [Hw-1:0]             r_h   [bsmh_pkg::MaxBoxes];
    logic [bsmh_pkg::MaxBoxes-1:0] r_done;
    logic [Cw-1:0] r_count, r_j, r_left;
    logic [Iw-1:0] r_i, r_pi;
    logic [bsmh_pkg::SumW-1:0] r_bsum;
    logic          r_ovf;
    logic [bsmh_pkg::BoxW-1:0] r_cur, r_rb;
    logic [Hw-1:0] r_below, r_best, r_rh;
    logic          r_rdv, r_rdone;
    logic [Hw:0]   sum_h;
    logic [bsmh_pkg::SumW-1:0] jsum;
    logic [Dw-1:0] cu0, cu1, cu2, rb0, rb1, rb2;

    assign o_q_pop = (r_state == ST_LOAD) && i_q_valid;
    assign {cu2, cu1, cu0} = r_cur;
    assign {rb2, rb1, rb0} = r_rb;
    assign jsum = bsmh_pkg::SumW'(rb0) + bsmh_pkg::SumW'(rb1) + bsmh_pkg::SumW'(rb2);
    assign sum_h = (Hw+1)'(r_below) + (Hw+1)'(cu2);
    assign o_valid = (r_state == ST_OUT);
    assign o_max_height = r_best;

    // store writes and registered store reads
    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_word.drop) begin
            r_box[r_count[Iw-1:0]] <= i_q_word.box;
        end
        if (r_state == ST_WRITE) begin
            r_h[r_i] <= r_below;
        end
        r_rb  <= r_box[r_j[Iw-1:0]];
        r_rh  <= r_h[r_j[Iw-1:0]];
        r_rdone <= r_done[r_j[Iw-1:0]];
    end

    // sequencer: pick unfinished box with smallest (sum, index), scan all done boxes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_count <= '0; r_ovf <= 1'b0; r_done <= '0;
            r_j <= '0; r_rdv <= 1'b0; r_left <= '0; r_best <= '0; o_overflow <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (o_q_pop) begin
                        if (i_q_word.drop) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_q_word.last) begin
                            r_left  <= r_count + Cw'(!i_q_word.drop);
                            r_count <= r_count + Cw'(!i_q_word.drop);
                            o_overflow <= r_ovf | i_q_word.drop;
                            r_best  <= '0;
                            r_done  <= '0;
                            r_j <= '0; r_rdv <= 1'b0;
                            r_bsum <= '1;
                            r_state <= (r_count + Cw'(!i_q_word.drop) == '0) ? ST_OUT : ST_PICK;
                        end else if (!i_q_word.drop) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                ST_PICK: begin
                    // pipelined scan: address r_j, data next cycle at r_pi
                    r_rdv <= (r_j < r_count);
                    r_pi  <= r_j[Iw-1:0];
                    if (r_j < r_count) r_j <= r_j + 1'b1;
                    if (r_rdv && !r_rdone && (jsum < r_bsum || (r_bsum == '1 && jsum == '1
                        && r_bsum == jsum && 1'b0))) begin
                        r_bsum <= jsum; r_i <= r_pi; r_cur <= r_rb;
                    end else if (r_rdv && !r_rdone && r_bsum == '1 && jsum == '1) begin
                        r_bsum <= jsum; r_i <= r_pi; r_cur <= r_rb;
                    end
                    if (!r_rdv && r_j == r_count) begin
                        r_j <= '0; r_below <= '0; r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_rdv <= (r_j < r_count);
                    if (r_j < r_count) r_j <= r_j + 1'b1;
                    if (r_rdv && r_rdone && rb0 <= cu0 && rb1 <= cu1 && rb2 <= cu2
                        && r_rh > r_below) begin
                        r_below <= r_rh;
                    end
                    if (!r_rdv && r_j == r_count) begin
                        r_below <= sum_h[Hw] ? '1 : sum_h[Hw-1:0];
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_done[r_i] <= 1'b1;
                    if (r_below > r_best) r_best <= r_below;
                    r_left <= r_left - 1'b1;
                    r_j <= '0; r_rdv <= 1'b0; r_bsum <= '1;
                    r_state <= (r_left == Cw'(1)) ? ST_OUT : ST_PICK;
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_count <= '0; r_ovf <= 1'b0; r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end
endmodule

@@ rtl/box_stacking_max_height_unit.sv @@
// Top level of the box stacking height unit.
// Loading: boxes load at one per cycle while the solver waits in its load state;
// with n stored boxes the solver then makes two passes over the store plus a write
// per box, then offers the result.
// Throughput: one set at a time; meanwhile the front queue takes up to four boxes.
// Reset: synchronous active-low i_rst_n clears control state; stores need none.
module box_stacking_max_height_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [bsmh_pkg::DimWidth-1:0] i_dim_a,
    input  logic [bsmh_pkg::DimWidth-1:0] i_dim_b,
    input  logic [bsmh_pkg::DimWidth-1:0] i_dim_c,
    input  logic        i_last_box,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [bsmh_pkg::HeightW-1:0] o_max_height,
    output logic        o_overflow
);
    logic q_valid, q_pop;
    bsmh_pkg::t_qword q_word;

    bsmh_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_dim_a, .i_dim_b, .i_dim_c,
        .i_last_box, .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_word(q_word)
    );

    bsmh_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_word(q_word),
        .o_valid, .i_ready, .o_max_height, .o_overflow
    );

    // a pop only happens with a word present
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    // the solver takes no word while a result waits
    a_no_pop_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !q_pop) else $error("pop while result pending");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_max_height))
        else $error("result changed while stalled");
endmodule

@@ tb/box_stacking_max_height_unit_tb.sv @@
// Testbench for the box stacking height unit: directed and random box sets.
`timescale 1ns / 100ps

module box_stacking_max_height_unit_tb;

    typedef struct {
        logic [15:0] height;
        logic        ovf;
    } t_stack_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [9:0]  i_dim_a = '0;
    logic [9:0]  i_dim_b = '0;
    logic [9:0]  i_dim_c = '0;
    logic        i_last_box = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_max_height;
    logic        o_overflow;

    // predictor state: one set of sorted boxes
    logic [9:0]    set_lo[bsmh_pkg::MaxBoxes];
    logic [9:0]    set_mid[bsmh_pkg::MaxBoxes];
    logic [9:0]    set_hi[bsmh_pkg::MaxBoxes];
    int            set_count = 0;
    bit            set_dropped = 0;
    t_stack_result expected_heights[$];

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;

    box_stacking_max_height_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR %0t: %s", $time, what);
    endtask

    // tallest stack over the stored boxes, dynamic program ordered by dim sum
    function automatic logic [15:0] tallest_stack();
        int order[bsmh_pkg::MaxBoxes];
        int top[bsmh_pkg::MaxBoxes];
        int best;
        int below;
        int cur;
        int j;
        best = 0;
        for (int i = 0; i < set_count; i++) begin
            j = i;
            while (j > 0 && (int'(set_lo[order[j-1]]) + int'(set_mid[order[j-1]])
                    + int'(set_hi[order[j-1]]))
                    > (int'(set_lo[i]) + int'(set_mid[i]) + int'(set_hi[i]))) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < set_count; i++) begin
            cur = order[i];
            below = 0;
            for (int k = 0; k < i; k++) begin
                if (set_lo[order[k]] <= set_lo[cur] && set_mid[order[k]] <= set_mid[cur] &&
                        set_hi[order[k]] <= set_hi[cur] && top[order[k]] > below)
                    below = top[order[k]];
            end
            top[cur] = below + set_hi[cur];
            if (top[cur] > 65535) top[cur] = 65535;
            if (top[cur] > best) best = top[cur];
        end
        return best[15:0];
    endfunction

    task automatic stack_box(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c);
        logic [9:0] t;
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        if (set_count < bsmh_pkg::MaxBoxes) begin
            set_lo[set_count] = a;
            set_mid[set_count] = b;
            set_hi[set_count] = c;
            set_count++;
        end else begin
            set_dropped = 1;
        end
    endtask

    // drive one word and wait for acceptance; prediction at acceptance
    task automatic send_box(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c,
                            input logic last);
        t_stack_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_dim_a <= a;
        i_dim_b <= b;
        i_dim_c <= c;
        i_last_box <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        stack_box(a, b, c);
        if (last) begin
            r.height = tallest_stack();
            r.ovf = set_dropped;
            expected_heights.insert(expected_heights.size(), r);
            set_count = 0;
            set_dropped = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic send_random_set(input int n);
        logic [9:0] lim;
        lim = ($urandom_range(3) == 0) ? 10'd1023 : 10'($urandom_range(15) + 1);
        for (int i = 0; i < n; i++)
            send_box(10'($urandom_range(lim)), 10'($urandom_range(lim)),
                     10'($urandom_range(lim)), i == n - 1);
    endtask

    // receiver ready, with random stalls and an optional long hold
    always @(negedge i_clk) begin
        i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_heights.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                if (o_max_height !== expected_heights[0].height)
                    report_mismatch($sformatf("height %0d want %0d", o_max_height,
                                              expected_heights[0].height));
                if (o_overflow !== expected_heights[0].ovf)
                    report_mismatch($sformatf("overflow %0b want %0b", o_overflow,
                                              expected_heights[0].ovf));
                void'(expected_heights.pop_front());
            end
        end
    end

    task automatic test_extremes();
        send_box(10'd0, 10'd0, 10'd0, 1'b1);
        send_box(10'd1023, 10'd1023, 10'd1023, 1'b1);
        send_box(10'd1023, 10'd0, 10'd512, 1'b0);
        send_box(10'd341, 10'd682, 10'd1023, 1'b1);
        // identical boxes stack
        send_box(10'd5, 10'd7, 10'd9, 1'b0);
        send_box(10'd9, 10'd5, 10'd7, 1'b0);
        send_box(10'd7, 10'd9, 10'd5, 1'b1);
        // two boxes that sort alike, then a box larger in every dimension
        send_box(10'd1, 10'd10, 10'd20, 1'b0);
        send_box(10'd10, 10'd1, 10'd20, 1'b0);
        send_box(10'd2, 10'd11, 10'd21, 1'b1);
    endtask

    task automatic test_store_full();
        for (int i = 0; i < bsmh_pkg::MaxBoxes + 3; i++)
            send_box(10'(1023 - i), 10'(1023 - i), 10'(1023 - i),
                     i == bsmh_pkg::MaxBoxes + 2);
        for (int i = 0; i < bsmh_pkg::MaxBoxes; i++)
            send_box(10'($urandom), 10'($urandom), 10'($urandom),
                     i == bsmh_pkg::MaxBoxes - 1);
    endtask

    task automatic test_random(input int boxes);
        int sent;
        int n;
        sent = 0;
        while (sent < boxes) begin
            n = ($urandom_range(15) == 0) ? $urandom_range(70, 40) : $urandom_range(8, 1);
            send_random_set(n);
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        recv_hold = 1;
        fork
            begin
                for (int i = 0; i < 10; i++) send_random_set(3);
            end
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 0;
            end
        join
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_heights.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 6;
        recv_idle_pct = 78;
        test_extremes();
        test_store_full();
        test_random(250);
        send_idle_pct = 78;
        recv_idle_pct = 6;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(200);
        drain();
        if (error_count == 0 && expected_heights.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
